// ----- design/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is low
`define QOI_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("qoi encoder check failed");

// clocked check that also holds during reset
`define QOI_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("qoi encoder check failed");

`endif

// ----- design/qoi_enc_pkg.sv -----
// shared constants and word types of the qoi pixel encoder
`default_nettype none

package qoi_enc_pkg;

	// color table geometry and hash bias (alpha fixed at 255)
	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);
	localparam int unsigned ALPHA       = 255;
	localparam int unsigned HASH_BIAS   = (11 * ALPHA) % TABLE_DEPTH;

	// run length limit and counter width
	localparam int unsigned RUN_LIMIT = 62;
	localparam int unsigned RUN_W     = 6;

	// chunk opcodes
	localparam logic [7:0] OP_RUN  = 8'hC0;
	localparam logic [7:0] OP_DIFF = 8'h40;
	localparam logic [7:0] OP_RGB  = 8'hFE;

	// decoupling queue, depth a power of two
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// what follows the optional run byte of a classified pixel
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ONE  = 2'd1,
		KIND_RGB  = 2'd2
	} kind_t;

	// one classified pixel handed from front to back
	typedef struct packed {
		logic       has_run;
		logic [7:0] run_byte;
		kind_t      kind;
		logic [7:0] op_byte;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} entry_t;

endpackage

`default_nettype wire

// ----- design/qoi_enc_front.sv -----
// front end: pixel register, color table, run tracking and chunk classification
`default_nettype none

module qoi_enc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	output logic                pixel_stall,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  logic                final_pixel,
	output logic                push,
	output qoi_enc_pkg::entry_t push_entry,
	input  logic                full
);

	localparam int unsigned AW    = qoi_enc_pkg::TABLE_AW;
	localparam int unsigned RUN_W = qoi_enc_pkg::RUN_W;

	// hash position of a color
	function automatic logic [AW-1:0] hash_pos(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [11:0] sum;
		sum = 12'(r) * 12'd3 + 12'(g) * 12'd5 + 12'(b) * 12'd7;
		return AW'(sum) + AW'(qoi_enc_pkg::HASH_BIAS);
	endfunction

	// delta within -2..1 on a 9-bit two's complement difference
	function automatic logic small_delta(input logic [8:0] d);
		return (d == 9'h1FE) || (d == 9'h1FF) || (d == 9'h000) || (d == 9'h001);
	endfunction

	logic                  s1_valid_q;
	logic [7:0]            red_s1;
	logic [7:0]            green_s1;
	logic [7:0]            blue_s1;
	logic                  final_s1;
	logic [AW-1:0]         pos_s1;
	logic [23:0]           rd_s1;
	logic [23:0]           ctab_mem_q [qoi_enc_pkg::TABLE_DEPTH];
	logic [qoi_enc_pkg::TABLE_DEPTH-1:0] tab_valid_q;
	logic [23:0]           prev_q;
	logic [RUN_W-1:0]      run_q;
	logic                  fwd_valid_q;
	logic [AW-1:0]         fwd_pos_q;
	logic [23:0]           fwd_color_q;

	logic                  accept;
	logic                  commit;
	logic [23:0]           color_s1;
	logic                  same;
	logic [RUN_W-1:0]      run_inc;
	logic                  run_flush;
	logic [23:0]           entry_color;
	logic                  hit;
	logic [8:0]            dr;
	logic [8:0]            dg;
	logic [8:0]            db;
	logic [1:0]            dr_code;
	logic [1:0]            dg_code;
	logic [1:0]            db_code;
	logic                  small_all;
	logic                  need_push;
	logic                  tab_wr;
	qoi_enc_pkg::entry_t   ent;

	// handshake: the pixel stage drains into the queue whenever it has room
	assign commit      = s1_valid_q && !full;
	assign pixel_stall = s1_valid_q && full;
	assign accept      = pixel_valid && !pixel_stall;

	// table lookup data, newest write forwarded over the registered read
	assign color_s1    = {red_s1, green_s1, blue_s1};
	assign entry_color = (fwd_valid_q && (fwd_pos_q == pos_s1)) ? fwd_color_q : rd_s1;
	assign hit         = tab_valid_q[pos_s1] && (entry_color == color_s1);

	// run tracking
	assign same      = (color_s1 == prev_q);
	assign run_inc   = run_q + RUN_W'(1);
	assign run_flush = (run_inc == RUN_W'(qoi_enc_pkg::RUN_LIMIT)) || final_s1;

	// channel deltas against the previous color
	assign dr        = {1'b0, red_s1} - {1'b0, prev_q[23:16]};
	assign dg        = {1'b0, green_s1} - {1'b0, prev_q[15:8]};
	assign db        = {1'b0, blue_s1} - {1'b0, prev_q[7:0]};
	assign dr_code   = dr[1:0] + 2'd2;
	assign dg_code   = dg[1:0] + 2'd2;
	assign db_code   = db[1:0] + 2'd2;
	assign small_all = small_delta(dr) && small_delta(dg) && small_delta(db);

	// classify the pixel into a queue word
	always_comb begin
		ent          = '0;
		ent.kind     = qoi_enc_pkg::KIND_NONE;
		ent.red      = red_s1;
		ent.green    = green_s1;
		ent.blue     = blue_s1;
		need_push    = 1'b0;
		tab_wr       = 1'b0;
		if (same) begin
			if (run_flush) begin
				ent.has_run  = 1'b1;
				ent.run_byte = qoi_enc_pkg::OP_RUN | 8'(run_q);
				need_push    = 1'b1;
			end
		end else begin
			need_push    = 1'b1;
			ent.has_run  = (run_q != '0);
			ent.run_byte = qoi_enc_pkg::OP_RUN | 8'(run_q - RUN_W'(1));
			if (hit) begin
				ent.kind    = qoi_enc_pkg::KIND_ONE;
				ent.op_byte = 8'(pos_s1);
			end else begin
				tab_wr = 1'b1;
				if (small_all) begin
					ent.kind    = qoi_enc_pkg::KIND_ONE;
					ent.op_byte = qoi_enc_pkg::OP_DIFF | {2'b00, dr_code, dg_code, db_code};
				end else begin
					ent.kind    = qoi_enc_pkg::KIND_RGB;
					ent.op_byte = qoi_enc_pkg::OP_RGB;
				end
			end
		end
	end

	assign push       = commit && need_push;
	assign push_entry = ent;

	// pixel stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	// pixel stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			final_s1 <= final_pixel;
			pos_s1   <= hash_pos(red, green, blue);
		end
	end

	// color table memory, registered read at the incoming pixel's hash
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= ctab_mem_q[hash_pos(red, green, blue)];
		end
		if (commit && tab_wr) begin
			ctab_mem_q[pos_s1] <= color_s1;
		end
	end

	// last table write, covers a read issued at the same edge
	always_ff @(posedge clk) begin
		if (commit && tab_wr) begin
			fwd_pos_q   <= pos_s1;
			fwd_color_q <= color_s1;
		end
	end

	// encoder state: valid bits, previous color, run count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_valid_q <= '0;
			prev_q      <= '0;
			run_q       <= '0;
			fwd_valid_q <= 1'b0;
		end else if (commit) begin
			if (tab_wr) begin
				fwd_valid_q <= 1'b1;
			end
			if (final_s1) begin
				tab_valid_q <= '0;
				prev_q      <= '0;
				run_q       <= '0;
			end else if (same) begin
				run_q <= run_flush ? '0 : run_inc;
			end else begin
				prev_q <= color_s1;
				run_q  <= '0;
				if (tab_wr) begin
					tab_valid_q[pos_s1] <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/qoi_enc_queue.sv -----
// short queue of classified pixel words between front and back
`default_nettype none

module qoi_enc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  qoi_enc_pkg::entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output qoi_enc_pkg::entry_t head
);

	localparam int unsigned QAW = qoi_enc_pkg::QUEUE_AW;

	qoi_enc_pkg::entry_t slot_q [qoi_enc_pkg::QUEUE_DEPTH];
	logic [QAW-1:0]      wr_ptr_q;
	logic [QAW-1:0]      rd_ptr_q;
	logic [QAW:0]        count_q;

	// status and head word
	assign full       = (count_q == (QAW + 1)'(qoi_enc_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QAW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QAW + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/qoi_enc_back.sv -----
// back end: expands queue words into chunk bytes through the output register
`default_nettype none

module qoi_enc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  qoi_enc_pkg::entry_t head,
	output logic                pop,
	output logic                code_valid,
	input  logic                code_stall,
	output logic [7:0]          code_byte,
	output logic                last_of_pixel
);

	logic [2:0] step_q;
	logic       code_valid_q;
	logic [7:0] code_byte_q;
	logic       last_q;

	logic [2:0] body_len;
	logic [2:0] word_len;
	logic [2:0] body_step;
	logic [7:0] next_byte;
	logic       is_last;
	logic       load;

	// byte count of the head word
	always_comb begin
		unique case (head.kind)
			qoi_enc_pkg::KIND_ONE: body_len = 3'd1;
			qoi_enc_pkg::KIND_RGB: body_len = 3'd4;
			default:               body_len = 3'd0;
		endcase
	end

	assign word_len  = body_len + 3'(head.has_run);
	assign body_step = head.has_run ? step_q - 3'd1 : step_q;
	assign is_last   = (step_q == word_len - 3'd1);

	// byte at the current step
	always_comb begin
		if (head.has_run && (step_q == 3'd0)) begin
			next_byte = head.run_byte;
		end else begin
			unique case (head.kind)
				qoi_enc_pkg::KIND_ONE: next_byte = head.op_byte;
				qoi_enc_pkg::KIND_RGB: begin
					unique case (body_step)
						3'd0:    next_byte = qoi_enc_pkg::OP_RGB;
						3'd1:    next_byte = head.red;
						3'd2:    next_byte = head.green;
						default: next_byte = head.blue;
					endcase
				end
				default: next_byte = head.run_byte;
			endcase
		end
	end

	// output register takes a byte when empty or being drained
	assign load = head_valid && (!code_valid_q || !code_stall);
	assign pop  = load && is_last;

	// step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			code_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q       <= is_last ? 3'd0 : step_q + 3'd1;
				code_valid_q <= 1'b1;
			end else if (!code_stall) begin
				code_valid_q <= 1'b0;
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (load) begin
			code_byte_q <= next_byte;
			last_q      <= is_last;
		end
	end

	assign code_valid    = code_valid_q;
	assign code_byte     = code_byte_q;
	assign last_of_pixel = last_q;

endmodule

`default_nettype wire

// ----- design/qoi_rgb_pixel_encoder.sv -----
// top level of the qoi rgb pixel encoder
//
//   channel  | direction | handshake                 | word
//   ---------+-----------+---------------------------+-------------------------------
//   pixel    | in        | pixel_valid / pixel_stall | red, green, blue, final_pixel
//   code     | out       | code_valid / code_stall   | code_byte, last_of_pixel
//
// a pixel is taken every cycle while the four-word queue has room; the back end
// sends one byte per cycle while code_stall is low, so a run or index or diff pixel
// is one byte, a run flush adds one byte and an rgb literal is four bytes.
// the first byte of a pixel passes the pixel stage, the queue and the output register.
// reset clears the color table valid bits, previous color and run count at once.
// output stall backs up into the queue, then the pixel stage, then pixel_stall.
`default_nettype none

module qoi_rgb_pixel_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	output logic       pixel_stall,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       final_pixel,
	output logic       code_valid,
	input  logic       code_stall,
	output logic [7:0] code_byte,
	output logic       last_of_pixel
);

	logic                push;
	qoi_enc_pkg::entry_t push_entry;
	logic                full;
	logic                pop;
	logic                head_valid;
	qoi_enc_pkg::entry_t head;

	// classification and table
	qoi_enc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.final_pixel (final_pixel),
		.push        (push),
		.push_entry  (push_entry),
		.full        (full)
	);

	// decoupling queue
	qoi_enc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// byte expansion
	qoi_enc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.code_valid    (code_valid),
		.code_stall    (code_stall),
		.code_byte     (code_byte),
		.last_of_pixel (last_of_pixel)
	);

endmodule

`default_nettype wire

// ----- design/qoi_enc_checker.sv -----
// port-level checks of the qoi pixel encoder and their binding
`default_nettype none
`include "assert_macros.svh"

module qoi_enc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pixel_stall,
	input logic       code_valid,
	input logic       code_stall,
	input logic [7:0] code_byte,
	input logic       last_of_pixel
);

	// stalled output word holds
	`QOI_ASSERT(a_code_hold, clk, arst_n, (code_valid && code_stall) |=> (code_valid && $stable(code_byte) && $stable(last_of_pixel)))

	// a pixel's first byte, when it directly follows a taken last byte, is never 0xff, which no run byte reaches
	`QOI_ASSERT(a_chunk_start, clk, arst_n, (code_valid && !code_stall && last_of_pixel) |=> !(code_valid && (code_byte == 8'hFF)))

	// quiet ports once reset has been held over a clock edge
	`QOI_ASSERT_ALWAYS(a_reset_quiet, clk, (!arst_n && $past(!arst_n)) |-> (!code_valid && !pixel_stall))

endmodule

bind qoi_rgb_pixel_encoder qoi_enc_checker u_qoi_enc_checker (.*);

`default_nettype wire

// ----- tb/tb_qoi_rgb_pixel_encoder.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the qoi rgb pixel encoder with a byte-exact scoreboard
module tb_qoi_rgb_pixel_encoder;

	localparam int RANDOM_ITEMS = 420;
	localparam int TAIL_ITEMS   = 40;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       eoi;
	} pixel_word_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_of_pixel;
	} code_word_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       pixel_valid = 1'b0;
	logic       pixel_stall;
	logic [7:0] red         = 8'd0;
	logic [7:0] green       = 8'd0;
	logic [7:0] blue        = 8'd0;
	logic       final_pixel = 1'b0;
	logic       code_valid;
	logic       code_stall  = 1'b0;
	logic [7:0] code_byte;
	logic       last_of_pixel;

	// pixels still to be offered and bytes still owed by the encoder
	pixel_word_t pending_pixels[$];
	code_word_t  expected_codes[$];

	// mirror of the encoder state
	logic [24:0] color_memo [qoi_enc_pkg::TABLE_DEPTH];
	logic [23:0] prev_color = 24'd0;
	logic [5:0]  run_len    = 6'd0;

	logic [23:0] gen_last       = 24'd0;
	int          mismatch_count = 0;
	int          pixels_taken   = 0;
	int          gap_left       = 0;
	int          stall_left     = 0;
	int          hold_count     = 0;
	int          cycle_count    = 0;
	logic        hold_active    = 1'b0;
	logic        hold_done      = 1'b0;
	logic        quiet_tail     = 1'b0;

	qoi_rgb_pixel_encoder uut (.*);

	always #2 clk = ~clk;

	function automatic void push_code(input logic [7:0] code, input logic last);
		code_word_t w;
		w.code_byte = code;
		w.last_of_pixel = last;
		expected_codes.push_back(w);
	endfunction

	function automatic void clear_model();
		foreach (color_memo[i]) color_memo[i] = '0;
		prev_color = '0;
		run_len = '0;
	endfunction

	// expected chunk bytes for one taken pixel
	task automatic encode_pixel(input logic [7:0] r, g, b, input logic eoi);
		logic [23:0] color;
		logic [5:0]  pos;
		int unsigned hsum;
		int          dr, dg, db;
		logic [1:0]  qr, qg, qb;
		color = {r, g, b};
		if (color == prev_color) begin
			run_len = run_len + 6'd1;
			if (run_len == qoi_enc_pkg::RUN_LIMIT || eoi) begin
				push_code(qoi_enc_pkg::OP_RUN | {2'b00, run_len - 6'd1}, 1'b1);
				run_len = '0;
			end
		end else begin
			hsum = 3 * r + 5 * g + 7 * b + 11 * qoi_enc_pkg::ALPHA;
			pos = 6'(hsum % qoi_enc_pkg::TABLE_DEPTH);
			// a pending run goes out ahead of the new color
			if (run_len != 0) begin
				push_code(qoi_enc_pkg::OP_RUN | {2'b00, run_len - 6'd1}, 1'b0);
				run_len = '0;
			end
			if (color_memo[pos][24] && color_memo[pos][23:0] == color) begin
				push_code({2'b00, pos}, 1'b1);
			end else begin
				// plain integer deltas, no wraparound
				dr = int'(r) - int'(prev_color[23:16]);
				dg = int'(g) - int'(prev_color[15:8]);
				db = int'(b) - int'(prev_color[7:0]);
				color_memo[pos] = {1'b1, color};
				if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
					qr = 2'(dr + 2);
					qg = 2'(dg + 2);
					qb = 2'(db + 2);
					push_code(qoi_enc_pkg::OP_DIFF | {2'b00, qr, qg, qb}, 1'b1);
				end else begin
					push_code(qoi_enc_pkg::OP_RGB, 1'b0);
					push_code(r, 1'b0);
					push_code(g, 1'b0);
					push_code(b, 1'b1);
				end
			end
			prev_color = color;
		end
		if (eoi) clear_model();
	endtask

	function automatic void add_pixel(input logic [23:0] color, input logic eoi);
		pixel_word_t w;
		w.red = color[23:16];
		w.green = color[15:8];
		w.blue = color[7:0];
		w.eoi = eoi;
		pending_pixels.push_back(w);
		gen_last = eoi ? 24'd0 : color;
	endfunction

	function automatic logic maybe_end();
		return $urandom_range(0, 39) == 0;
	endfunction

	function automatic logic [7:0] step_channel(input logic [7:0] v, input int lo, input int hi);
		int d;
		d = lo + int'($urandom_range(0, hi - lo));
		return 8'(int'(v) + d);
	endfunction

	// pixel driver with random gaps between words
	always @(posedge clk or negedge arst_n) begin : pixel_driver
		pixel_word_t w;
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			red <= 8'd0;
			green <= 8'd0;
			blue <= 8'd0;
			final_pixel <= 1'b0;
			gap_left <= 0;
			quiet_tail <= 1'b0;
		end else if (!pixel_valid || !pixel_stall) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				pixel_valid <= 1'b0;
			end else if (pending_pixels.size() > 0) begin
				w = pending_pixels.pop_front();
				red <= w.red;
				green <= w.green;
				blue <= w.blue;
				final_pixel <= w.eoi;
				pixel_valid <= 1'b1;
				if (!quiet_tail && !hold_active && $urandom_range(0, 5) == 0)
					gap_left <= $urandom_range(1, 15);
			end else begin
				pixel_valid <= 1'b0;
			end
			quiet_tail <= pending_pixels.size() <= TAIL_ITEMS;
		end
	end

	// long receiver hold-off once the stream is under way
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_active <= 1'b0;
			hold_done <= 1'b0;
			hold_count <= 0;
		end else if (!hold_done && pixels_taken >= HOLD_AT) begin
			if (hold_count == HOLD_CYCLES) begin
				hold_active <= 1'b0;
				hold_done <= 1'b1;
			end else begin
				hold_active <= 1'b1;
				hold_count <= hold_count + 1;
			end
		end
	end

	// monitor: predict on taken pixels, check taken bytes, drive code_stall
	always @(posedge clk or negedge arst_n) begin : code_monitor
		code_word_t want;
		logic       stall_next;
		if (!arst_n) begin
			code_stall <= 1'b0;
			stall_left <= 0;
			pixels_taken <= 0;
			clear_model();
		end else begin
			if (pixel_valid && !pixel_stall) begin
				encode_pixel(red, green, blue, final_pixel);
				pixels_taken <= pixels_taken + 1;
			end
			if (code_valid && !code_stall) begin
				if (expected_codes.size() == 0) begin
					$error("code_byte: expected none, got %h", code_byte);
					mismatch_count++;
				end else begin
					want = expected_codes.pop_front();
					if (code_byte !== want.code_byte) begin
						$error("code_byte: expected %h, got %h", want.code_byte, code_byte);
						mismatch_count++;
					end
					if (last_of_pixel !== want.last_of_pixel) begin
						$error("last_of_pixel: expected %b, got %b",
							want.last_of_pixel, last_of_pixel);
						mismatch_count++;
					end
				end
			end
			// stall bursts, none started in the tail
			if (hold_active) begin
				stall_next = 1'b1;
			end else if (stall_left > 0) begin
				stall_next = 1'b1;
				stall_left <= stall_left - 1;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				stall_next = 1'b1;
				stall_left <= $urandom_range(0, 14);
			end else begin
				stall_next = 1'b0;
			end
			code_stall <= stall_next;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		logic [23:0] palette [8];
		logic [23:0] color;
		int          item_goal, pick, reps, long_runs, k;
		long_runs = 0;

		// directed: runs, diff extremes, literal without wrap, index hits, final pixels
		add_pixel(24'h000000, 1'b0);
		add_pixel(24'h000000, 1'b0);
		add_pixel(24'h010101, 1'b0);
		add_pixel(24'hFFFFFF, 1'b0);
		// black lands on a never-written slot whose valid bit is still clear
		add_pixel(24'h000000, 1'b0);
		add_pixel(24'hFFFFFF, 1'b0);
		add_pixel(24'hFE007F, 1'b0);
		add_pixel(24'hFC0180, 1'b0);
		add_pixel(24'hFC0180, 1'b1);
		add_pixel(24'h000000, 1'b1);
		add_pixel(24'h020000, 1'b0);
		// final pixel that differs leaves no run behind
		add_pixel(24'h000000, 1'b1);
		add_pixel(24'h808080, 1'b0);
		add_pixel(24'h7F7E81, 1'b0);
		add_pixel(24'h808080, 1'b0);
		add_pixel(24'h55AA55, 1'b0);
		add_pixel(24'hAA55AA, 1'b0);
		add_pixel(24'hAA55AA, 1'b0);
		add_pixel(24'hAA55AA, 1'b0);
		add_pixel(24'h808080, 1'b0);
		add_pixel(24'hFF00FF, 1'b1);

		// random: mostly palette hits, small steps and runs, some literals and near misses
		for (k = 0; k < 8; k++) palette[k] = 24'($urandom);
		item_goal = pending_pixels.size() + RANDOM_ITEMS;
		while (pending_pixels.size() < item_goal) begin
			pick = $urandom_range(0, 15);
			if (pick < 4) begin
				k = $urandom_range(0, 7);
				if ($urandom_range(0, 15) == 0) palette[k] = 24'($urandom);
				add_pixel(palette[k], maybe_end());
			end else if (pick < 8) begin
				color = {step_channel(gen_last[23:16], -2, 1),
					step_channel(gen_last[15:8], -2, 1),
					step_channel(gen_last[7:0], -2, 1)};
				add_pixel(color, maybe_end());
			end else if (pick < 11 || (pick == 11 && long_runs >= 3)) begin
				reps = $urandom_range(1, 6);
				repeat (reps) add_pixel(gen_last, maybe_end());
			end else if (pick == 11) begin
				// long run of 60 to 70 repeats, which hits the run limit from 62 repeats on
				long_runs++;
				reps = $urandom_range(60, 70);
				repeat (reps) add_pixel(gen_last, 1'b0);
			end else if (pick < 15) begin
				add_pixel(24'($urandom), maybe_end());
			end else begin
				// one channel just outside the diff range
				color = {step_channel(gen_last[23:16], -2, 1),
					step_channel(gen_last[15:8], -2, 1),
					step_channel(gen_last[7:0], -2, 1)};
				if ($urandom_range(0, 1) == 0)
					color[15:8] = step_channel(gen_last[15:8], 2, 3);
				else
					color[15:8] = step_channel(gen_last[15:8], -4, -3);
				add_pixel(color, maybe_end());
			end
		end
		add_pixel(24'($urandom), 1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all pixels taken, all bytes seen, then a short drain
		@(negedge clk);
		while (pending_pixels.size() != 0 || pixel_valid) @(negedge clk);
		while (expected_codes.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- qoi_rgb_pixel_encoder.f -----
+incdir+design
design/qoi_enc_pkg.sv
design/qoi_enc_front.sv
design/qoi_enc_queue.sv
design/qoi_enc_back.sv
design/qoi_rgb_pixel_encoder.sv
design/qoi_enc_checker.sv
tb/tb_qoi_rgb_pixel_encoder.sv
